>>> sv/sesd_pkg.sv
package sesd_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int TRACK_BITS  = 16;
    localparam int SECTOR_BITS = 16;
    localparam int CFG_BITS    = 16;
    localparam int SLOT_FIELD  = 3;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_BITS-1:0] MAX_TRACK_RESET = '1;

    localparam logic ACT_POST  = 1'b0;
    localparam logic ACT_SERVE = 1'b1;

    // One classified command waiting between the front and the back.
    typedef struct packed {
        logic                   is_serve;
        logic                   slot_ok;
        logic [SLOT_W-1:0]      slot_idx;
        logic [TRACK_BITS-1:0]  track;
        logic [SECTOR_BITS-1:0] sector;
        logic                   is_write;
    } cmd_t;

endpackage

>>> sv/scan_elevator_disk_scheduler.sv
// Post beat: queued, popped into the work register, then written to the result
// register once the output can load; the back end stays busy until then.
// Serve beat: popped likewise, scanned one slot per cycle, then written out.
// A two-beat queue lets the front take new beats while the back end scans.
// Reset (asynchronous, active low): all slots free, head on track 0, sweeping
// up, max_track at its top value, queue and output empty. No clearing pass.
module scan_elevator_disk_scheduler
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: max_track, taken whenever cfg_we is high
    input  logic                               cfg_we,
    input  logic [sesd_pkg::CFG_BITS-1:0]      cfg_wdata,
    // Request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [sesd_pkg::SLOT_FIELD-1:0]    slot,
    input  logic [sesd_pkg::TRACK_BITS-1:0]    track,
    input  logic [sesd_pkg::SECTOR_BITS-1:0]   sector,
    input  logic                               is_write,
    // Result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               served_valid,
    output logic [sesd_pkg::SLOT_FIELD-1:0]    served_slot,
    output logic [sesd_pkg::TRACK_BITS-1:0]    served_track,
    output logic [sesd_pkg::SECTOR_BITS-1:0]   served_sector,
    output logic                               served_write,
    output logic                               seek_needed,
    output logic                               sweep_down,
    output logic                               post_error
);

    logic [sesd_pkg::CFG_BITS-1:0] max_track_reg;
    logic                          cmd_valid;
    sesd_pkg::cmd_t                cmd;
    logic                          cmd_pop;

    // Hold the highest legal track; the head does not follow requests beyond it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_track_reg <= sesd_pkg::MAX_TRACK_RESET;
        else if (cfg_we)
            max_track_reg <= cfg_wdata;
    end

    // Front end: classify each beat and park it in the queue.
    sesd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .slot      (slot),
        .track     (track),
        .sector    (sector),
        .is_write  (is_write),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: store posts, scan the slots for serves, drive the result beat.
    sesd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .max_track     (max_track_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .served_valid  (served_valid),
        .served_slot   (served_slot),
        .served_track  (served_track),
        .served_sector (served_sector),
        .served_write  (served_write),
        .seek_needed   (seek_needed),
        .sweep_down    (sweep_down),
        .post_error    (post_error)
    );

endmodule

>>> sv/sesd_front.sv
module sesd_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [sesd_pkg::SLOT_FIELD-1:0]    slot,
    input  logic [sesd_pkg::TRACK_BITS-1:0]    track,
    input  logic [sesd_pkg::SECTOR_BITS-1:0]   sector,
    input  logic                               is_write,
    output logic                               cmd_valid,
    output sesd_pkg::cmd_t                     cmd,
    input  logic                               cmd_pop
);

    sesd_pkg::cmd_t                   queue_reg [sesd_pkg::QUEUE_DEPTH];
    logic [sesd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [sesd_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [sesd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [sesd_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [sesd_pkg::QCNT_W-1:0]      count_reg;
    logic [sesd_pkg::QCNT_W-1:0]      count_next;
    sesd_pkg::cmd_t                   cmd_in;
    logic                             push;
    logic                             pop;

    // Classify the beat: out-of-range slots are flagged here.
    always_comb
    begin
        cmd_in.is_serve = (action == sesd_pkg::ACT_SERVE);
        cmd_in.slot_ok  = (32'(slot) < sesd_pkg::NUM_SLOTS);
        cmd_in.slot_idx = sesd_pkg::SLOT_W'(slot);
        cmd_in.track    = track;
        cmd_in.sector   = sector;
        cmd_in.is_write = is_write;
    end

    assign in_stall  = (count_reg == sesd_pkg::QCNT_W'(sesd_pkg::QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == sesd_pkg::QPTR_W'(sesd_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == sesd_pkg::QPTR_W'(sesd_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

>>> sv/sesd_back.sv
module sesd_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  sesd_pkg::cmd_t                     cmd,
    output logic                               cmd_pop,
    input  logic [sesd_pkg::CFG_BITS-1:0]      max_track,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               served_valid,
    output logic [sesd_pkg::SLOT_FIELD-1:0]    served_slot,
    output logic [sesd_pkg::TRACK_BITS-1:0]    served_track,
    output logic [sesd_pkg::SECTOR_BITS-1:0]   served_sector,
    output logic                               served_write,
    output logic                               seek_needed,
    output logic                               sweep_down,
    output logic                               post_error
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POST = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    sesd_pkg::cmd_t                      work_reg;
    logic [sesd_pkg::NUM_SLOTS-1:0]      pending_reg;
    logic [sesd_pkg::TRACK_BITS-1:0]     slot_track_reg [sesd_pkg::NUM_SLOTS];
    logic [sesd_pkg::SECTOR_BITS-1:0]    slot_sector_reg [sesd_pkg::NUM_SLOTS];
    logic                                slot_write_reg [sesd_pkg::NUM_SLOTS];
    logic [sesd_pkg::TRACK_BITS-1:0]     head_reg;
    logic                                dir_down_reg;
    logic [sesd_pkg::SLOT_W-1:0]         scan_idx_reg;
    logic                                found_reg;
    logic [sesd_pkg::SLOT_W-1:0]         best_idx_reg;
    logic [sesd_pkg::TRACK_BITS-1:0]     best_track_reg;
    logic [sesd_pkg::SECTOR_BITS-1:0]    best_sector_reg;
    logic                                best_write_reg;
    logic                                out_valid_reg;
    logic                                res_valid_reg;
    logic [sesd_pkg::SLOT_FIELD-1:0]     res_slot_reg;
    logic [sesd_pkg::TRACK_BITS-1:0]     res_track_reg;
    logic [sesd_pkg::SECTOR_BITS-1:0]    res_sector_reg;
    logic                                res_write_reg;
    logic                                res_seek_reg;
    logic                                res_down_reg;
    logic                                res_error_reg;

    logic                                load_ok;
    logic                                post_err;
    logic                                post_commit;
    logic                                serve_commit;
    logic [sesd_pkg::TRACK_BITS-1:0]     scan_track;
    logic                                scan_qual;
    logic                                scan_better;
    logic                                scan_take;
    logic                                scan_last;

    assign load_ok  = !out_valid_reg || !out_stall;
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
    assign post_err = !work_reg.slot_ok || pending_reg[work_reg.slot_idx];
    assign post_commit  = (state_reg == ST_POST) && load_ok;
    assign serve_commit = (state_reg == ST_DONE) && load_ok;

    // One slot examined per cycle; strict compare keeps the lowest slot on ties.
    assign scan_track  = slot_track_reg[scan_idx_reg];
    assign scan_qual   = pending_reg[scan_idx_reg] &&
                         (dir_down_reg ? (scan_track <= head_reg) : (scan_track >= head_reg));
    assign scan_better = !found_reg ||
                         (dir_down_reg ? (scan_track > best_track_reg)
                                       : (scan_track < best_track_reg));
    assign scan_take   = (state_reg == ST_SCAN) && scan_qual && scan_better;
    assign scan_last   = (scan_idx_reg == sesd_pkg::SLOT_W'(sesd_pkg::NUM_SLOTS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = cmd.is_serve ? ST_SCAN : ST_POST;
            end
            ST_POST:
            begin
                if (load_ok)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_ok)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= '0;
            head_reg      <= '0;
            dir_down_reg  <= 1'b0;
            found_reg     <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop)
            begin
                found_reg    <= 1'b0;
                scan_idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (!scan_last)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_take)
                    found_reg <= 1'b1;
            end
            if (post_commit && !post_err)
                pending_reg[work_reg.slot_idx] <= 1'b1;
            if (serve_commit)
            begin
                if (found_reg)
                begin
                    pending_reg[best_idx_reg] <= 1'b0;
                    if (32'(best_track_reg) <= 32'(max_track))
                        head_reg <= best_track_reg;
                end
                else
                begin
                    dir_down_reg <= !dir_down_reg;
                end
            end
            if (post_commit || serve_commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: work item, scan winner, slot store and result beat.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            work_reg <= cmd;
        if (scan_take)
        begin
            best_idx_reg    <= scan_idx_reg;
            best_track_reg  <= scan_track;
            best_sector_reg <= slot_sector_reg[scan_idx_reg];
            best_write_reg  <= slot_write_reg[scan_idx_reg];
        end
        if (post_commit && !post_err)
        begin
            slot_track_reg[work_reg.slot_idx]  <= work_reg.track;
            slot_sector_reg[work_reg.slot_idx] <= work_reg.sector;
            slot_write_reg[work_reg.slot_idx]  <= work_reg.is_write;
        end
        if (post_commit)
        begin
            res_valid_reg  <= 1'b0;
            res_slot_reg   <= '0;
            res_track_reg  <= '0;
            res_sector_reg <= '0;
            res_write_reg  <= 1'b0;
            res_seek_reg   <= 1'b0;
            res_down_reg   <= dir_down_reg;
            res_error_reg  <= post_err;
        end
        else if (serve_commit)
        begin
            res_error_reg <= 1'b0;
            if (found_reg)
            begin
                res_valid_reg  <= 1'b1;
                res_slot_reg   <= sesd_pkg::SLOT_FIELD'(best_idx_reg);
                res_track_reg  <= best_track_reg;
                res_sector_reg <= best_sector_reg;
                res_write_reg  <= best_write_reg;
                res_seek_reg   <= (best_track_reg != head_reg);
                res_down_reg   <= dir_down_reg;
            end
            else
            begin
                res_valid_reg  <= 1'b0;
                res_slot_reg   <= '0;
                res_track_reg  <= '0;
                res_sector_reg <= '0;
                res_write_reg  <= 1'b0;
                res_seek_reg   <= 1'b0;
                res_down_reg   <= !dir_down_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign served_valid  = res_valid_reg;
    assign served_slot   = res_slot_reg;
    assign served_track  = res_track_reg;
    assign served_sector = res_sector_reg;
    assign served_write  = res_write_reg;
    assign seek_needed   = res_seek_reg;
    assign sweep_down    = res_down_reg;
    assign post_error    = res_error_reg;

endmodule
